[sv/bcd_time_of_day_clock_assert.svh]
// Assertion macros for the BCD time-of-day clock.
`ifndef BCD_TIME_OF_DAY_CLOCK_ASSERT_SVH
`define BCD_TIME_OF_DAY_CLOCK_ASSERT_SVH

`ifndef SYNTHESIS
`define BCDTOD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bcd time-of-day clock check failed");
`define BCDTOD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcd time-of-day clock check failed");
`else
`define BCDTOD_ASSERT(name, clk, rst, prop)
`define BCDTOD_ASSERT_IMP(name, clk, rst, ante, cons)
`endif

`endif

[sv/bcdtod_pkg.sv]
// Types, constants and BCD helpers shared by the time-of-day clock.
`default_nettype none

package bcdtod_pkg;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;

   localparam logic [7:0] SECONDS_LAST  = 8'h59;
   localparam logic [7:0] MINUTES_LAST  = 8'h59;
   localparam logic [7:0] HOURS_LAST    = 8'h23;
   localparam logic [7:0] MINUTES_BOUND = 8'h60;
   localparam logic [7:0] HOURS_BOUND   = 8'h24;
   localparam logic [3:0] DIGIT_MAX     = 4'd9;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_DIGIT = 2'd1,
      OP_OK    = 2'd2,
      OP_OTHER = 2'd3
   } op_type;

   typedef struct packed {
      logic [6:0] seconds;
      logic [6:0] minutes;
      logic [5:0] hours;
      logic [7:0] entry_hours;
      logic [7:0] entry_minutes;
      logic       setting;
   } tod_state_type;

   typedef struct packed {
      logic [6:0] seconds;
      logic [6:0] minutes;
      logic [5:0] hours;
      logic       minute_start;
      logic       setting_active;
      logic [7:0] entry_hours;
      logic [7:0] entry_minutes;
      logic       time_loaded;
   } tod_result_type;

   // Increments a valid packed BCD pair and wraps to zero after the last value.
   function automatic logic [7:0] bcd_inc(input logic [7:0] value, input logic [7:0] last);
      logic [7:0] next;
      if (value == last) begin
         next = 8'h00;
      end else if (value[3:0] == DIGIT_MAX) begin
         next = {value[7:4] + 4'd1, 4'd0};
      end else begin
         next = value + 8'd1;
      end
      return next;
   endfunction

endpackage

`default_nettype wire

[sv/bcdtod_update.sv]
// Next-state and result logic for one tick or key word.
`default_nettype none

module bcdtod_update (
   input  var bcdtod_pkg::op_type         op,
   input  var logic [3:0]                 digit,
   input  var bcdtod_pkg::tod_state_type  state,
   output bcdtod_pkg::tod_state_type      state_next,
   output bcdtod_pkg::tod_result_type     result
);

   bcdtod_pkg::op_type op_eff;
   logic               wrapped;
   logic               loaded;
   logic               entry_ok;
   logic [7:0]         sec_inc;
   logic [7:0]         min_inc;
   logic [7:0]         hour_inc;

   always_comb begin
      op_eff = op;
      if (op == bcdtod_pkg::OP_DIGIT && digit > bcdtod_pkg::DIGIT_MAX) begin
         op_eff = bcdtod_pkg::OP_OTHER;
      end
   end

   assign sec_inc  = bcdtod_pkg::bcd_inc({1'b0, state.seconds}, bcdtod_pkg::SECONDS_LAST);
   assign min_inc  = bcdtod_pkg::bcd_inc({1'b0, state.minutes}, bcdtod_pkg::MINUTES_LAST);
   assign hour_inc = bcdtod_pkg::bcd_inc({2'b00, state.hours}, bcdtod_pkg::HOURS_LAST);
   assign entry_ok = (state.entry_minutes < bcdtod_pkg::MINUTES_BOUND) &&
                     (state.entry_hours < bcdtod_pkg::HOURS_BOUND);

   always_comb begin
      state_next = state;
      wrapped    = 1'b0;
      loaded     = 1'b0;
      case (op_eff)
         bcdtod_pkg::OP_TICK: begin
            state_next.seconds = sec_inc[6:0];
            if ({1'b0, state.seconds} == bcdtod_pkg::SECONDS_LAST) begin
               wrapped            = 1'b1;
               state_next.minutes = min_inc[6:0];
               if ({1'b0, state.minutes} == bcdtod_pkg::MINUTES_LAST) begin
                  state_next.hours = hour_inc[5:0];
               end
            end
         end
         bcdtod_pkg::OP_DIGIT: begin
            state_next.entry_hours   = {state.entry_hours[3:0], state.entry_minutes[7:4]};
            state_next.entry_minutes = {state.entry_minutes[3:0], digit};
            state_next.setting       = 1'b1;
         end
         bcdtod_pkg::OP_OK, bcdtod_pkg::OP_OTHER: begin
            if (state.setting) begin
               if (op_eff == bcdtod_pkg::OP_OK && entry_ok) begin
                  state_next.seconds = 7'd0;
                  state_next.minutes = state.entry_minutes[6:0];
                  state_next.hours   = state.entry_hours[5:0];
                  loaded             = 1'b1;
               end
               state_next.entry_hours   = 8'h00;
               state_next.entry_minutes = 8'h00;
               state_next.setting       = 1'b0;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

   always_comb begin
      result.seconds        = state_next.seconds;
      result.minutes        = state_next.minutes;
      result.hours          = state_next.hours;
      result.minute_start   = wrapped;
      result.setting_active = state_next.setting;
      result.entry_hours    = state_next.entry_hours;
      result.entry_minutes  = state_next.entry_minutes;
      result.time_loaded    = loaded;
   end

endmodule

`default_nettype wire

[sv/bcd_time_of_day_clock.sv]
// Top level of the 24-hour BCD time-of-day clock with keypad time entry.
// An accepted word is held in the input register; the update logic's result is registered
// in the result register, which drives rsp_.
// Throughput: one word per cycle unless rsp_tready is held low; the input and result
// registers each advance whenever the stage after them is empty or is being drained.
// Reset clears the time, the entry, setting mode and both valid flags.
`default_nettype none

`include "bcd_time_of_day_clock_assert.svh"

module bcd_time_of_day_clock (
   input  var logic                            clock,
   input  var logic                            reset,
   input  var logic                            req_tvalid,
   output logic                                req_tready,
   input  var logic [bcdtod_pkg::REQ_DATA_W-1:0] req_tdata,  // digit[3:0], zero[7:4]
   input  var logic [bcdtod_pkg::REQ_USER_W-1:0] req_tuser,  // op[1:0]
   output logic                                rsp_tvalid,
   input  var logic                            rsp_tready,
   // seconds_bcd[6:0], minutes_bcd[13:7], hours_bcd[19:14], minute_start[20],
   // setting_active[21], entry_hours_bcd[29:22], entry_minutes_bcd[37:30],
   // time_loaded[38], zero[39]
   output logic [bcdtod_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic                        in_valid_ff;
   logic                        in_valid_in;
   bcdtod_pkg::op_type          in_op_ff;
   logic [3:0]                  in_digit_ff;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   bcdtod_pkg::tod_result_type  result_ff;
   bcdtod_pkg::tod_result_type  result_in;
   bcdtod_pkg::tod_state_type   state_ff;
   bcdtod_pkg::tod_state_type   state_in;
   logic                        advance;
   logic                        req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_op_ff    <= bcdtod_pkg::op_type'(req_tuser);
         in_digit_ff <= req_tdata[3:0];
      end
   end

   bcdtod_update u_update (
      .op         (in_op_ff),
      .digit      (in_digit_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0,
                        result_ff.time_loaded,
                        result_ff.entry_minutes,
                        result_ff.entry_hours,
                        result_ff.setting_active,
                        result_ff.minute_start,
                        result_ff.hours,
                        result_ff.minutes,
                        result_ff.seconds};

   `BCDTOD_ASSERT(a_time_in_range, clock, reset,
      ({1'b0, state_ff.seconds} <= bcdtod_pkg::SECONDS_LAST) &&
      ({1'b0, state_ff.minutes} <= bcdtod_pkg::MINUTES_LAST) &&
      ({2'b00, state_ff.hours} <= bcdtod_pkg::HOURS_LAST))
   `BCDTOD_ASSERT_IMP(a_entry_clear_idle, clock, reset, !state_ff.setting,
      (state_ff.entry_hours == 8'h00) && (state_ff.entry_minutes == 8'h00))
   `BCDTOD_ASSERT_IMP(a_wrap_zero_seconds, clock, reset,
      out_valid_ff && result_ff.minute_start,
      (result_ff.seconds == 7'd0) && !result_ff.time_loaded)
   `BCDTOD_ASSERT_IMP(a_load_leaves_setting, clock, reset,
      out_valid_ff && result_ff.time_loaded,
      !result_ff.setting_active && (result_ff.seconds == 7'd0))
   `BCDTOD_ASSERT(a_advance_fills_output, clock, reset, advance |=> out_valid_ff)

endmodule

`default_nettype wire

[test/tb_bcd_time_of_day_clock.sv]
// Self-checking testbench for the BCD time-of-day clock with keypad time entry.
module tb_bcd_time_of_day_clock;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int unsigned LONG_HOLD      = 60;
   localparam logic [7:0]  SECONDS_BOUND  = 8'h60;
   localparam logic [3:0]  DIGIT_OVERFLOW = 4'ha;
   localparam logic [7:0]  BCD_ADJUST     = 8'h06;

   typedef struct packed {
      logic       pad;
      logic       time_loaded;
      logic [7:0] entry_minutes;
      logic [7:0] entry_hours;
      logic       setting_active;
      logic       minute_start;
      logic [5:0] hours;
      logic [6:0] minutes;
      logic [6:0] seconds;
   } clock_word_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [bcdtod_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [bcdtod_pkg::REQ_USER_W-1:0] req_tuser  = bcdtod_pkg::OP_TICK;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [bcdtod_pkg::RSP_DATA_W-1:0] rsp_tdata;

   logic [7:0] model_seconds       = 8'h00;
   logic [7:0] model_minutes       = 8'h00;
   logic [7:0] model_hours         = 8'h00;
   logic [7:0] model_entry_hours   = 8'h00;
   logic [7:0] model_entry_minutes = 8'h00;
   logic       model_setting       = 1'b0;

   clock_word_type expected_words[$];

   int unsigned mismatches        = 0;
   int unsigned words_sent        = 0;
   int unsigned results_checked   = 0;
   int unsigned minute_rollovers  = 0;
   int unsigned day_rollovers     = 0;
   int unsigned loads_accepted    = 0;
   int unsigned loads_rejected    = 0;
   int unsigned cycle_count       = 0;
   int unsigned long_hold_request = 0;
   int unsigned hold_left         = 0;
   bit          idle_enabled      = 1'b1;

   bcd_time_of_day_clock dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_words.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [7:0] bcd_step(input logic [7:0] value, input logic [7:0] bound);
      logic [7:0] next_value;
      next_value = value + 8'd1;
      if (next_value[3:0] >= DIGIT_OVERFLOW) next_value = next_value + BCD_ADJUST;
      if (next_value >= bound) next_value = 8'h00;
      return next_value;
   endfunction

   function automatic clock_word_type advance_clock(input bcdtod_pkg::op_type op,
                                                    input logic [3:0] digit);
      bcdtod_pkg::op_type kind;
      clock_word_type     word;
      kind = op;
      word = '0;
      if (kind == bcdtod_pkg::OP_DIGIT && digit > bcdtod_pkg::DIGIT_MAX)
         kind = bcdtod_pkg::OP_OTHER;
      case (kind)
         bcdtod_pkg::OP_TICK: begin
            model_seconds = bcd_step(model_seconds, SECONDS_BOUND);
            if (model_seconds == 8'h00) begin
               word.minute_start = 1'b1;
               minute_rollovers++;
               model_minutes = bcd_step(model_minutes, bcdtod_pkg::MINUTES_BOUND);
               if (model_minutes == 8'h00) begin
                  model_hours = bcd_step(model_hours, bcdtod_pkg::HOURS_BOUND);
                  if (model_hours == 8'h00) day_rollovers++;
               end
            end
         end
         bcdtod_pkg::OP_DIGIT: begin
            model_entry_hours   = {model_entry_hours[3:0], model_entry_minutes[7:4]};
            model_entry_minutes = {model_entry_minutes[3:0], digit};
            model_setting       = 1'b1;
         end
         default: begin
            if (model_setting) begin
               if (kind == bcdtod_pkg::OP_OK &&
                   model_entry_minutes < bcdtod_pkg::MINUTES_BOUND &&
                   model_entry_hours < bcdtod_pkg::HOURS_BOUND) begin
                  model_seconds     = 8'h00;
                  model_minutes     = model_entry_minutes;
                  model_hours       = model_entry_hours;
                  word.time_loaded  = 1'b1;
                  loads_accepted++;
               end else if (kind == bcdtod_pkg::OP_OK) begin
                  loads_rejected++;
               end
               model_entry_hours   = 8'h00;
               model_entry_minutes = 8'h00;
               model_setting       = 1'b0;
            end
         end
      endcase
      word.seconds        = model_seconds[6:0];
      word.minutes        = model_minutes[6:0];
      word.hours          = model_hours[5:0];
      word.setting_active = model_setting;
      word.entry_hours    = model_entry_hours;
      word.entry_minutes  = model_entry_minutes;
      return word;
   endfunction

   task automatic check_word(input clock_word_type actual);
      clock_word_type expected;
      string          wrong;
      if (expected_words.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("Result %h arrived with no word outstanding.", actual);
      end else begin
         expected = expected_words.pop_front();
         wrong = "";
         if (actual.seconds !== expected.seconds) wrong = {wrong, " seconds"};
         if (actual.minutes !== expected.minutes) wrong = {wrong, " minutes"};
         if (actual.hours !== expected.hours) wrong = {wrong, " hours"};
         if (actual.minute_start !== expected.minute_start) wrong = {wrong, " minute_start"};
         if (actual.setting_active !== expected.setting_active)
            wrong = {wrong, " setting_active"};
         if (actual.entry_hours !== expected.entry_hours) wrong = {wrong, " entry_hours"};
         if (actual.entry_minutes !== expected.entry_minutes) wrong = {wrong, " entry_minutes"};
         if (actual.time_loaded !== expected.time_loaded) wrong = {wrong, " time_loaded"};
         if (actual.pad !== expected.pad) wrong = {wrong, " padding"};
         if (wrong != "") begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Result %0d wrong in%s: expected %h, got %h.",
                        results_checked, wrong, expected, actual);
         end
         results_checked++;
      end
   endtask

   // The receiver takes results, checks them and stalls in random bursts or on request.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_word(clock_word_type'(rsp_tdata));
      if (long_hold_request != 0) begin
         hold_left = long_hold_request;
         long_hold_request = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_word(input bcdtod_pkg::op_type op, input logic [3:0] digit);
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(bcdtod_pkg::REQ_DATA_W - 4){1'b0}}, digit};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_words.push_back(advance_clock(op, digit));
      words_sent++;
   endtask

   task automatic key_in_time(input logic [7:0] hh, input logic [7:0] mm);
      send_word(bcdtod_pkg::OP_DIGIT, hh[7:4]);
      send_word(bcdtod_pkg::OP_DIGIT, hh[3:0]);
      send_word(bcdtod_pkg::OP_DIGIT, mm[7:4]);
      send_word(bcdtod_pkg::OP_DIGIT, mm[3:0]);
   endtask

   task automatic send_ticks(input int unsigned count);
      repeat (count) send_word(bcdtod_pkg::OP_TICK, 4'($urandom_range(0, 15)));
   endtask

   task automatic test_stray_keys();
      send_word(bcdtod_pkg::OP_OK, 4'd0);
      send_word(bcdtod_pkg::OP_OTHER, 4'd15);
      send_word(bcdtod_pkg::OP_DIGIT, 4'd12);
   endtask

   task automatic test_time_entry();
      key_in_time(bcdtod_pkg::HOURS_LAST, bcdtod_pkg::MINUTES_LAST);
      send_word(bcdtod_pkg::OP_OK, 4'd0);
      key_in_time(bcdtod_pkg::HOURS_BOUND, 8'h00);
      send_word(bcdtod_pkg::OP_OK, 4'd0);
      key_in_time(bcdtod_pkg::HOURS_LAST, bcdtod_pkg::MINUTES_BOUND);
      send_word(bcdtod_pkg::OP_OK, 4'd0);
      repeat (5) send_word(bcdtod_pkg::OP_DIGIT, bcdtod_pkg::DIGIT_MAX);
      send_word(bcdtod_pkg::OP_OTHER, 4'd0);
      send_word(bcdtod_pkg::OP_DIGIT, 4'd1);
      send_word(bcdtod_pkg::OP_DIGIT, 4'd15);
      send_word(bcdtod_pkg::OP_DIGIT, 4'd0);
      send_word(bcdtod_pkg::OP_TICK, 4'd0);
      send_word(bcdtod_pkg::OP_OK, 4'd0);
   endtask

   task automatic test_day_rollover();
      key_in_time(8'h09, bcdtod_pkg::MINUTES_LAST);
      send_word(bcdtod_pkg::OP_OK, 4'd0);
      send_ticks(60);
      key_in_time(bcdtod_pkg::HOURS_LAST, bcdtod_pkg::MINUTES_LAST);
      send_word(bcdtod_pkg::OP_OK, 4'd0);
      send_ticks(61);
   endtask

   task automatic test_output_backpressure();
      long_hold_request = LONG_HOLD;
      send_ticks(30);
   endtask

   task automatic test_random_traffic(input int unsigned word_count);
      int unsigned target;
      int unsigned choice;
      logic [7:0]  hh;
      logic [7:0]  mm;
      target = words_sent + word_count;
      while (words_sent < target) begin
         choice = $urandom_range(0, 99);
         if (choice < 55) begin
            if ($urandom_range(0, 3) == 0) begin
               hh = bcdtod_pkg::HOURS_LAST;
               mm = bcdtod_pkg::MINUTES_LAST;
            end else begin
               hh[7:4] = 4'($urandom_range(0, 2));
               hh[3:0] = (hh[7:4] == 4'd2) ? 4'($urandom_range(0, 3))
                                           : 4'($urandom_range(0, 9));
               mm[7:4] = 4'($urandom_range(0, 5));
               mm[3:0] = 4'($urandom_range(0, 9));
            end
            key_in_time(hh, mm);
            if ($urandom_range(0, 3) == 0)
               send_word(bcdtod_pkg::OP_TICK, 4'($urandom_range(0, 15)));
            send_word(bcdtod_pkg::OP_OK, 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 2) == 0) send_ticks($urandom_range(40, 90));
            else send_ticks($urandom_range(0, 8));
         end else if (choice < 80) begin
            repeat ($urandom_range(1, 6))
               send_word(bcdtod_pkg::OP_DIGIT, 4'($urandom_range(0, 9)));
            case ($urandom_range(0, 3))
               0: send_word(bcdtod_pkg::OP_OK, 4'($urandom_range(0, 15)));
               1: send_word(bcdtod_pkg::OP_OTHER, 4'($urandom_range(0, 15)));
               2: send_word(bcdtod_pkg::OP_DIGIT, 4'($urandom_range(10, 15)));
               default: send_word(bcdtod_pkg::OP_TICK, 4'($urandom_range(0, 15)));
            endcase
         end else begin
            send_word(bcdtod_pkg::op_type'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_stray_keys();
      test_time_entry();
      test_day_rollover();
      test_output_backpressure();
      test_random_traffic(1000);
      idle_enabled = 1'b0;
      test_random_traffic(400);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d words and checked %0d results over %0d cycles.",
               words_sent, results_checked, cycle_count);
      $display("Saw %0d time loads, %0d rejected entries, %0d minute and %0d day rollovers.",
               loads_accepted, loads_rejected, minute_rollovers, day_rollovers);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d results were wrong.", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
